// File: sv/ogcm_pkg.sv
// ----------------------------------------------------------------------------
// ogcm_pkg
// shared types and constants for the occupancy grid clear and mask merge block
// ----------------------------------------------------------------------------
package ogcm_pkg;

	localparam int unsigned DEF_MAX_MAP_COLS = 256;
	localparam int unsigned DEF_MAX_MAP_ROWS = 256;
	localparam int unsigned DEF_MAX_MASK_DIM = 1024;

	localparam int unsigned CFG_W = 24;

	localparam logic signed [7:0] OCCUPIED_VAL = 8'sd100;
	localparam logic signed [7:0] FREE_VAL     = 8'sd0;
	localparam logic signed [7:0] OOR_VAL      = -8'sd1;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_MASK = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ROBOT_X       = 3'd0,
		REG_ROBOT_Y       = 3'd1,
		REG_FREE_RADIUS   = 3'd2,
		REG_MASK_OFFSET_X = 3'd3,
		REG_MASK_OFFSET_Y = 3'd4,
		REG_MASK_SCALE    = 3'd5,
		REG_MAP_COLS      = 3'd6,
		REG_MAP_ROWS      = 3'd7
	} reg_t;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_FREE     = 2'd1,
		OP_READ     = 2'd2,
		OP_READ_OOR = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [23:0] robot_x;
		logic signed [23:0] robot_y;
		logic [22:0]        free_radius;
		logic signed [23:0] mask_offset_x;
		logic signed [23:0] mask_offset_y;
		logic [15:0]        mask_scale;
		logic [8:0]         map_cols;
		logic [8:0]         map_rows;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic signed [7:0] data;
	} ctl_t;

endpackage

// File: sv/ogcm_queue.sv
// ----------------------------------------------------------------------------
// ogcm_queue
// two-entry fifo between the classifying front and the grid store back end
// ----------------------------------------------------------------------------
module ogcm_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/ogcm_front.sv
// ----------------------------------------------------------------------------
// ogcm_front
// takes a request, places it in map coordinates, tests the clear radius,
// floors to a map cell and, when one is due, queues a store operation
// ----------------------------------------------------------------------------
module ogcm_front import ogcm_pkg::*; #(
	parameter int unsigned MAX_MAP_COLS = DEF_MAX_MAP_COLS,
	parameter int unsigned MAX_MAP_ROWS = DEF_MAX_MAP_ROWS,
	parameter int unsigned MAX_MASK_DIM = DEF_MAX_MASK_DIM,
	parameter int unsigned ADDR_W       = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 cmd,
	input  logic [9:0]                 row,
	input  logic [9:0]                 col,
	input  logic signed [7:0]          cell_value,
	input  cfg_t                       cfg,
	input  logic                       full,
	output logic                       busy,
	output logic                       push,
	output logic [ADDR_W+$bits(ctl_t)-1:0] push_data
);

	typedef enum logic [1:0] {F_IDLE, F_SQ, F_CMP} fst_t;

	fst_t               st_q;
	cmd_t               cmd_q;
	logic [9:0]         row_q;
	logic [9:0]         col_q;
	logic signed [7:0]  val_q;
	logic signed [28:0] px2_q;
	logic signed [28:0] py2_q;
	logic signed [59:0] dx2_q;
	logic signed [59:0] dy2_q;
	logic [47:0]        r2sq_q;

	logic [26:0]        mx;
	logic [26:0]        my;
	logic signed [28:0] px2_in;
	logic signed [28:0] py2_in;
	logic signed [29:0] dx;
	logic signed [29:0] dy;
	logic [23:0]        r2;
	logic [60:0]        dist2;
	logic               near;
	logic [12:0]        cols_lim;
	logic [12:0]        rows_lim;
	logic [19:0]        mc;
	logic [19:0]        mr;
	logic               grid_ok;
	logic               mask_ok;
	logic               mask_in_map;
	logic               do_push;
	ctl_t               ctl;
	logic [ADDR_W-1:0]  addr;

	assign busy = (st_q != F_IDLE);

	// mask cell center, doubled
	assign mx = {col, 1'b1} * cfg.mask_scale;
	assign my = {row, 1'b1} * cfg.mask_scale;

	always_comb begin
		if (cmd_t'(cmd) == CMD_MASK) begin
			px2_in = {{4{cfg.mask_offset_x[23]}}, cfg.mask_offset_x, 1'b0} + {2'b0, mx};
			py2_in = {{4{cfg.mask_offset_y[23]}}, cfg.mask_offset_y, 1'b0} + {2'b0, my};
		end else begin
			px2_in = {10'b0, col, 1'b1, 8'b0};
			py2_in = {10'b0, row, 1'b1, 8'b0};
		end
	end

	assign dx = {px2_q[28], px2_q} - {{5{cfg.robot_x[23]}}, cfg.robot_x, 1'b0};
	assign dy = {py2_q[28], py2_q} - {{5{cfg.robot_y[23]}}, cfg.robot_y, 1'b0};
	assign r2 = {cfg.free_radius, 1'b0};

	assign dist2 = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign near  = (cfg.free_radius != 23'd0) && (dist2 <= {13'b0, r2sq_q});

	assign cols_lim = ({4'b0, cfg.map_cols} > 13'(MAX_MAP_COLS)) ?
		13'(MAX_MAP_COLS) : {4'b0, cfg.map_cols};
	assign rows_lim = ({4'b0, cfg.map_rows} > 13'(MAX_MAP_ROWS)) ?
		13'(MAX_MAP_ROWS) : {4'b0, cfg.map_rows};

	// floor to a map cell
	assign mc = px2_q[28:9];
	assign mr = py2_q[28:9];

	assign grid_ok = ({3'b0, row_q} < rows_lim) && ({3'b0, col_q} < cols_lim);
	assign mask_ok = !val_q[7]
		&& ({7'b0, row_q} < 17'(MAX_MASK_DIM))
		&& ({7'b0, col_q} < 17'(MAX_MASK_DIM));
	assign mask_in_map = !mc[19] && !mr[19]
		&& (mc < {7'b0, cols_lim}) && (mr < {7'b0, rows_lim});

	always_comb begin
		do_push  = 1'b0;
		ctl.op   = OP_WRITE;
		ctl.data = val_q;
		addr     = ADDR_W'(row_q) * ADDR_W'(MAX_MAP_COLS) + ADDR_W'(col_q);
		case (cmd_q)
			CMD_LOAD: begin
				do_push  = grid_ok;
				ctl.data = near ? FREE_VAL : val_q;
			end
			CMD_MASK: begin
				addr = ADDR_W'(mr) * ADDR_W'(MAX_MAP_COLS) + ADDR_W'(mc);
				if (mask_ok && !near && mask_in_map) begin
					if (val_q >= OCCUPIED_VAL) begin
						do_push  = 1'b1;
						ctl.data = OCCUPIED_VAL;
					end else if (val_q == FREE_VAL) begin
						do_push  = 1'b1;
						ctl.op   = OP_FREE;
						ctl.data = FREE_VAL;
					end
				end
			end
			CMD_READ: begin
				do_push = 1'b1;
				ctl.op  = grid_ok ? OP_READ : OP_READ_OOR;
			end
			default: begin
				do_push = 1'b0;
			end
		endcase
	end

	assign push      = (st_q == F_CMP) && do_push && !full;
	assign push_data = {addr, ctl};

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				cmd_q <= cmd_t'(cmd);
				row_q <= row;
				col_q <= col;
				val_q <= cell_value;
				px2_q <= px2_in;
				py2_q <= py2_in;
			end
			F_SQ: begin
				dx2_q  <= dx * dx;
				dy2_q  <= dy * dy;
				r2sq_q <= r2 * r2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			case (st_q)
				F_IDLE:  if (start) st_q <= F_SQ;
				F_SQ:    st_q <= F_CMP;
				F_CMP:   if (!do_push || !full) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: sv/ogcm_back.sv
// ----------------------------------------------------------------------------
// ogcm_back
// grid store: carries out queued writes, conditional frees and reads
// ----------------------------------------------------------------------------
module ogcm_back import ogcm_pkg::*; #(
	parameter int unsigned MAX_MAP_COLS = DEF_MAX_MAP_COLS,
	parameter int unsigned MAX_MAP_ROWS = DEF_MAX_MAP_ROWS,
	parameter int unsigned ADDR_W       = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	input  logic [ADDR_W+$bits(ctl_t)-1:0] head,
	output logic                           pop,
	output logic                           done,
	output logic signed [7:0]              read_value
);

	localparam int unsigned DEPTH = MAX_MAP_ROWS * MAX_MAP_COLS;

	typedef enum logic [1:0] {B_IDLE, B_FREE, B_RD} bst_t;

	logic signed [7:0] mem [DEPTH];

	bst_t              st_q;
	logic [ADDR_W-1:0] addr_q;
	logic signed [7:0] rd_q;
	logic              done_q;
	logic signed [7:0] read_value_q;

	logic [ADDR_W-1:0] head_addr;
	ctl_t              head_ctl;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic signed [7:0] mem_wdata;

	assign head_addr = head[ADDR_W+$bits(ctl_t)-1:$bits(ctl_t)];
	assign head_ctl  = head[$bits(ctl_t)-1:0];

	assign pop = (st_q == B_IDLE) && !empty;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_addr;
		mem_wdata = head_ctl.data;
		if (pop && head_ctl.op == OP_WRITE) begin
			mem_we = 1'b1;
		end else if (st_q == B_FREE && rd_q[7]) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = FREE_VAL;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q   <= mem[head_addr];
		addr_q <= head_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_IDLE;
			done_q       <= 1'b0;
			read_value_q <= FREE_VAL;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (pop) begin
						case (head_ctl.op)
							OP_FREE: st_q <= B_FREE;
							OP_READ: st_q <= B_RD;
							OP_READ_OOR: begin
								done_q       <= 1'b1;
								read_value_q <= OOR_VAL;
							end
							default: st_q <= B_IDLE;
						endcase
					end
				end
				B_FREE: st_q <= B_IDLE;
				B_RD: begin
					done_q       <= 1'b1;
					read_value_q <= rd_q;
					st_q         <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;

endmodule

// File: sv/occupancy_grid_clear_and_mask_merge.sv
// ----------------------------------------------------------------------------
// occupancy_grid_clear_and_mask_merge
// occupancy grid store with robot-radius clearing and mask merging
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while the front end squares the distance to the robot (F_SQ) and floors the
// position to a map cell (F_CMP), and longer while the two-entry queue to the
// grid store is full, so no new request is taken until the front end is idle.
// The store carries out a write as it pops it; a free-if-unknown or read first
// reads the cell and then passes through B_FREE or B_RD. A read returns
// read_value with done high for exactly one cycle, after B_RD when in range
// and straight from the pop when out of range; results are never held back,
// so the receiver must take them when done is high. Load and mask requests
// give no result. Configuration is written through cfg_we, cfg_index and
// cfg_data and must only change while no request is in flight.
module occupancy_grid_clear_and_mask_merge import ogcm_pkg::*; #(
	parameter int unsigned MAX_MAP_COLS = DEF_MAX_MAP_COLS,
	parameter int unsigned MAX_MAP_ROWS = DEF_MAX_MAP_ROWS,
	parameter int unsigned MAX_MASK_DIM = DEF_MAX_MASK_DIM
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [9:0]        row,
	input  logic [9:0]        col,
	input  logic signed [7:0] cell_value,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              done,
	output logic signed [7:0] read_value
);

	localparam int unsigned CELLS  = MAX_MAP_ROWS * MAX_MAP_COLS;
	localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned QW     = ADDR_W + $bits(ctl_t);

	cfg_t          cfg_q;
	logic          push;
	logic [QW-1:0] push_data;
	logic          pop;
	logic [QW-1:0] head;
	logic          full;
	logic          empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.robot_x       <= '0;
			cfg_q.robot_y       <= '0;
			cfg_q.free_radius   <= '0;
			cfg_q.mask_offset_x <= '0;
			cfg_q.mask_offset_y <= '0;
			cfg_q.mask_scale    <= 16'd256;
			cfg_q.map_cols      <= 9'd256;
			cfg_q.map_rows      <= 9'd256;
		end else if (cfg_we) begin
			case (reg_t'(cfg_index))
				REG_ROBOT_X:       cfg_q.robot_x       <= cfg_data;
				REG_ROBOT_Y:       cfg_q.robot_y       <= cfg_data;
				REG_FREE_RADIUS:   cfg_q.free_radius   <= cfg_data[22:0];
				REG_MASK_OFFSET_X: cfg_q.mask_offset_x <= cfg_data;
				REG_MASK_OFFSET_Y: cfg_q.mask_offset_y <= cfg_data;
				REG_MASK_SCALE:    cfg_q.mask_scale    <= cfg_data[15:0];
				REG_MAP_COLS:      cfg_q.map_cols      <= cfg_data[8:0];
				REG_MAP_ROWS:      cfg_q.map_rows      <= cfg_data[8:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	ogcm_front #(
		.MAX_MAP_COLS (MAX_MAP_COLS),
		.MAX_MAP_ROWS (MAX_MAP_ROWS),
		.MAX_MASK_DIM (MAX_MASK_DIM),
		.ADDR_W       (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.row        (row),
		.col        (col),
		.cell_value (cell_value),
		.cfg        (cfg_q),
		.full       (full),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data)
	);

	ogcm_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	ogcm_back #(
		.MAX_MAP_COLS (MAX_MAP_COLS),
		.MAX_MAP_ROWS (MAX_MAP_ROWS),
		.ADDR_W       (ADDR_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.read_value (read_value)
	);

endmodule

// File: bench/grid_merge_checker.sv
// ----------------------------------------------------------------------------
// grid_merge_checker
// Watches the request, configuration and result ports of the occupancy grid
// block. It keeps its own copy of the grid and the registers, works out each
// read result when the read request is taken, and compares every result
// strobe with the oldest read still due. It reports mismatches and how many
// reads are still due.
// ----------------------------------------------------------------------------
module grid_merge_checker import ogcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        cmd,
	input  logic [9:0]        row,
	input  logic [9:0]        col,
	input  logic signed [7:0] cell_value,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              done,
	input  logic signed [7:0] read_value,
	output int unsigned       mismatches,
	output int unsigned       pending
);

	cfg_t              shadow;
	logic signed [7:0] grid [0:DEF_MAX_MAP_ROWS*DEF_MAX_MAP_COLS-1];
	logic signed [7:0] reads_due [$];

	function automatic int unsigned size_in_use(logic [8:0] size, int unsigned cap);
		return (size > cap) ? cap : size;
	endfunction

	// positions doubled, lsb 1/512 cell
	function automatic bit close_to_robot(longint px2, longint py2);
		longint dx, dy, r2;
		if (shadow.free_radius == '0)
			return 1'b0;
		dx = px2 - 2 * longint'(shadow.robot_x);
		dy = py2 - 2 * longint'(shadow.robot_y);
		r2 = 2 * longint'(shadow.free_radius);
		return dx * dx + dy * dy <= r2 * r2;
	endfunction

	task automatic update_register(logic [2:0] idx, logic [CFG_W-1:0] data);
		case (reg_t'(idx))
		REG_ROBOT_X:       shadow.robot_x = data[23:0];
		REG_ROBOT_Y:       shadow.robot_y = data[23:0];
		REG_FREE_RADIUS:   shadow.free_radius = data[22:0];
		REG_MASK_OFFSET_X: shadow.mask_offset_x = data[23:0];
		REG_MASK_OFFSET_Y: shadow.mask_offset_y = data[23:0];
		REG_MASK_SCALE:    shadow.mask_scale = data[15:0];
		REG_MAP_COLS:      shadow.map_cols = data[8:0];
		REG_MAP_ROWS:      shadow.map_rows = data[8:0];
		default: ;
		endcase
	endtask

	task automatic apply_grid_request(logic [1:0] c, logic [9:0] r, logic [9:0] k,
		logic signed [7:0] v);
		longint      wx2, wy2, mc, mr;
		int unsigned cols, rows, slot;
		cols = size_in_use(shadow.map_cols, DEF_MAX_MAP_COLS);
		rows = size_in_use(shadow.map_rows, DEF_MAX_MAP_ROWS);
		case (cmd_t'(c))
		CMD_LOAD: begin
			if (r < rows && k < cols) begin
				slot = r * DEF_MAX_MAP_COLS + k;
				grid[slot] = close_to_robot((2 * longint'(k) + 1) * 256,
					(2 * longint'(r) + 1) * 256) ? FREE_VAL : v;
			end
		end
		CMD_MASK: begin
			if (v >= 0 && r < DEF_MAX_MASK_DIM && k < DEF_MAX_MASK_DIM) begin
				wx2 = 2 * longint'(shadow.mask_offset_x)
					+ (2 * longint'(k) + 1) * longint'(shadow.mask_scale);
				wy2 = 2 * longint'(shadow.mask_offset_y)
					+ (2 * longint'(r) + 1) * longint'(shadow.mask_scale);
				mc = wx2 >>> 9;
				mr = wy2 >>> 9;
				if (!close_to_robot(wx2, wy2) && mc >= 0 && mr >= 0
					&& mc < longint'(cols) && mr < longint'(rows)) begin
					slot = 32'(mr) * DEF_MAX_MAP_COLS + 32'(mc);
					if (v >= OCCUPIED_VAL)
						grid[slot] = OCCUPIED_VAL;
					else if (v == FREE_VAL && grid[slot] < 0)
						grid[slot] = FREE_VAL;
				end
			end
		end
		CMD_READ: begin
			if (r < rows && k < cols)
				reads_due.push_back(grid[r * DEF_MAX_MAP_COLS + k]);
			else
				reads_due.push_back(OOR_VAL);
		end
		default: ;
		endcase
	endtask

	task automatic note_mismatch(string what, logic signed [7:0] want);
		mismatches++;
		if (mismatches <= 10)
			$display("t=%0t %s: expected %0d, got %0d", $time, what, want, read_value);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [7:0] want;
		if (!arst_n) begin
			shadow = '{robot_x: '0, robot_y: '0, free_radius: '0,
				mask_offset_x: '0, mask_offset_y: '0, mask_scale: 16'd256,
				map_cols: 9'd256, map_rows: 9'd256};
			reads_due.delete();
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (reads_due.size() == 0) begin
					note_mismatch("read result with no read request due", 'x);
				end else begin
					want = reads_due.pop_front();
					if (read_value !== want)
						note_mismatch("read_value mismatch", want);
				end
			end
			if (cfg_we)
				update_register(cfg_index, cfg_data);
			if (start && !busy)
				apply_grid_request(cmd, row, col, cell_value);
			pending <= reads_due.size();
		end
	end

endmodule

// File: bench/occupancy_grid_clear_and_mask_merge_tb.sv
// ----------------------------------------------------------------------------
// occupancy_grid_clear_and_mask_merge_tb
// Fills the corner of the grid store that every phase's map stays inside,
// then runs several configuration phases, each with random load, mask, read
// and idle requests, sometimes with random gaps between requests. The first
// phase opens with directed requests for clearing on and inside the radius,
// mask merging rules and out-of-range reads. The checker beside the block
// predicts and compares all read results.
// ----------------------------------------------------------------------------
module occupancy_grid_clear_and_mask_merge_tb;
	import ogcm_pkg::*;

	localparam int unsigned SETTLE_CYCLES   = 16;
	localparam int unsigned CYCLE_LIMIT     = 1_200_000;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 96;
	localparam int unsigned FILL_DIM        = 16;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        cmd;
	logic [9:0]        row;
	logic [9:0]        col;
	logic signed [7:0] cell_value;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              done;
	logic signed [7:0] read_value;
	int unsigned       mismatches;
	int unsigned       pending;
	int unsigned       cycle_count;

	logic [CFG_W-1:0]  reg_image [8];
	int unsigned       gap_percent [PHASES] = '{0, 56, 0, 29, 56, 0, 29, 56};

	occupancy_grid_clear_and_mask_merge dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.row        (row),
		.col        (col),
		.cell_value (cell_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.read_value (read_value)
	);

	grid_merge_checker merge_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.row        (row),
		.col        (col),
		.cell_value (cell_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.read_value (read_value),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[occupancy_grid_clear_and_mask_merge] ERROR");
			$finish;
		end
	end

	function automatic int unsigned size_in_use(logic [8:0] size);
		return (size > DEF_MAX_MAP_COLS) ? DEF_MAX_MAP_COLS : size;
	endfunction

	task automatic send_request(cmd_t c, logic [9:0] r, logic [9:0] k,
		logic signed [7:0] v, int unsigned gap_pct);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start      <= 1'b1;
		cmd        <= c;
		row        <= r;
		col        <= k;
		cell_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// all reads answered, then let loads and masks drain from the block
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_t'(i);
			cfg_data  <= reg_image[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pick_config(int unsigned phase);
		reg_image[REG_ROBOT_X]       = '0;
		reg_image[REG_ROBOT_Y]       = '0;
		reg_image[REG_FREE_RADIUS]   = '0;
		reg_image[REG_MASK_OFFSET_X] = '0;
		reg_image[REG_MASK_OFFSET_Y] = '0;
		reg_image[REG_MASK_SCALE]    = 24'd256;
		reg_image[REG_MAP_COLS]      = 24'd16;
		reg_image[REG_MAP_ROWS]      = 24'd16;
		case (phase)
		0: begin
			// robot on a cell center, radius of whole cells
			reg_image[REG_ROBOT_X]     = 24'd1408;
			reg_image[REG_ROBOT_Y]     = 24'd1408;
			reg_image[REG_FREE_RADIUS] = 24'd512;
		end
		1: begin
			reg_image[REG_ROBOT_X]       = CFG_W'($urandom_range(0, 16 * 256));
			reg_image[REG_ROBOT_Y]       = CFG_W'($urandom_range(0, 12 * 256));
			reg_image[REG_FREE_RADIUS]   = CFG_W'($urandom_range(0, 1536));
			reg_image[REG_MASK_OFFSET_X] = CFG_W'(-$urandom_range(0, 512));
			reg_image[REG_MASK_OFFSET_Y] = CFG_W'($urandom_range(0, 512));
			reg_image[REG_MASK_SCALE]    = 24'd128;
			reg_image[REG_MAP_COLS]      = 24'd16;
			reg_image[REG_MAP_ROWS]      = 24'd12;
		end
		2: begin
			reg_image[REG_ROBOT_X]       = CFG_W'($urandom_range(0, 12 * 256));
			reg_image[REG_ROBOT_Y]       = CFG_W'($urandom_range(0, 9 * 256));
			reg_image[REG_FREE_RADIUS]   = CFG_W'($urandom_range(0, 1024));
			reg_image[REG_MASK_OFFSET_X] = CFG_W'($urandom_range(0, 512) - 256);
			reg_image[REG_MASK_OFFSET_Y] = CFG_W'($urandom_range(0, 512) - 256);
			reg_image[REG_MASK_SCALE]    = 24'd512;
			reg_image[REG_MAP_COLS]      = 24'd12;
			reg_image[REG_MAP_ROWS]      = 24'd9;
		end
		3: begin
			reg_image[REG_ROBOT_X]       = 24'h7FFFFF;
			reg_image[REG_ROBOT_Y]       = 24'h800000;
			reg_image[REG_FREE_RADIUS]   = 24'h7FFFFF;
			reg_image[REG_MASK_OFFSET_X] = CFG_W'($urandom_range(0, 2048) - 1024);
			reg_image[REG_MASK_OFFSET_Y] = CFG_W'($urandom_range(0, 2048) - 1024);
			reg_image[REG_MASK_SCALE]    = 24'h00FFFF;
		end
		4: begin
			// no column in range, rows beyond the store
			reg_image[REG_ROBOT_X]       = CFG_W'($urandom);
			reg_image[REG_ROBOT_Y]       = CFG_W'($urandom);
			reg_image[REG_MASK_OFFSET_X] = 24'h800000;
			reg_image[REG_MASK_OFFSET_Y] = 24'h7FFFFF;
			reg_image[REG_MASK_SCALE]    = 24'd0;
			reg_image[REG_MAP_COLS]      = 24'd0;
			reg_image[REG_MAP_ROWS]      = 24'd300;
		end
		5: begin
			reg_image[REG_MASK_SCALE] = 24'd1;
			reg_image[REG_MAP_COLS]   = 24'd1;
			reg_image[REG_MAP_ROWS]   = 24'd1;
		end
		6: begin
			reg_image[REG_ROBOT_X]       = CFG_W'($urandom_range(0, 16 * 256));
			reg_image[REG_ROBOT_Y]       = CFG_W'($urandom_range(0, 16 * 256));
			reg_image[REG_FREE_RADIUS]   = CFG_W'($urandom_range(0, 4096));
			reg_image[REG_MASK_OFFSET_X] = CFG_W'($urandom_range(0, 4096) - 2048);
			reg_image[REG_MASK_OFFSET_Y] = CFG_W'($urandom_range(0, 4096) - 2048);
			reg_image[REG_MASK_SCALE]    = CFG_W'($urandom_range(1, 1024));
			reg_image[REG_MAP_COLS]      = CFG_W'($urandom_range(1, 16));
			reg_image[REG_MAP_ROWS]      = CFG_W'($urandom_range(1, 16));
		end
		default: begin
			reg_image[REG_ROBOT_X]       = CFG_W'(-$urandom_range(0, 512));
			reg_image[REG_ROBOT_Y]       = CFG_W'($urandom_range(0, 16 * 256));
			reg_image[REG_FREE_RADIUS]   = CFG_W'($urandom_range(256, 8192));
			reg_image[REG_MASK_OFFSET_X] = CFG_W'($urandom_range(0, 256) - 128);
			reg_image[REG_MASK_OFFSET_Y] = CFG_W'($urandom_range(0, 256) - 128);
		end
		endcase
	endtask

	task automatic random_request(int unsigned gap_pct);
		cmd_t              c;
		logic [9:0]        r, k;
		logic signed [7:0] v;
		logic [15:0]       scale;
		int unsigned       pick, cols, rows, lim_c, lim_r;
		scale = reg_image[REG_MASK_SCALE][15:0];
		cols  = size_in_use(reg_image[REG_MAP_COLS][8:0]);
		rows  = size_in_use(reg_image[REG_MAP_ROWS][8:0]);
		pick  = $urandom_range(0, 99);
		if (pick < 3)
			c = CMD_NONE;
		else if (pick < 33)
			c = CMD_LOAD;
		else if (pick < 68)
			c = CMD_MASK;
		else
			c = CMD_READ;
		// aim mask cells mostly at the map
		if (c == CMD_MASK) begin
			lim_c = (scale == 0) ? 1024 : cols * 256 / scale + 3;
			lim_r = (scale == 0) ? 1024 : rows * 256 / scale + 3;
		end else begin
			lim_c = cols + 1;
			lim_r = rows + 1;
		end
		if (lim_c > 1024)
			lim_c = 1024;
		if (lim_r > 1024)
			lim_r = 1024;
		r = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, lim_r - 1))
			: 10'($urandom_range(0, 1023));
		k = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, lim_c - 1))
			: 10'($urandom_range(0, 1023));
		pick = $urandom_range(0, 9);
		if (pick < 2)
			v = 8'(-$urandom_range(1, 128));
		else if (pick < 4)
			v = FREE_VAL;
		else if (pick < 6)
			v = 8'($urandom_range(100, 127));
		else if (pick < 7)
			v = 8'($urandom_range(1, 99));
		else
			v = 8'($urandom);
		send_request(c, r, k, v, gap_pct);
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		cmd        <= CMD_NONE;
		row        <= '0;
		col        <= '0;
		cell_value <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every cell of the corner in use written once before it is read or merged
		for (int r = 0; r < FILL_DIM; r++)
			for (int k = 0; k < FILL_DIM; k++)
				send_request(CMD_LOAD, 10'(r), 10'(k), 8'($urandom), 0);
		settle();

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			pick_config(phase);
			write_config();
			if (phase == 0) begin
				send_request(CMD_LOAD, 10'd0, 10'd0, 8'sh80, 0);
				send_request(CMD_READ, 10'd0, 10'd0, 8'sd0, 0);
				send_request(CMD_LOAD, 10'd5, 10'd7, 8'sd127, 0);    // center on the radius
				send_request(CMD_READ, 10'd5, 10'd7, 8'sd0, 0);
				send_request(CMD_LOAD, 10'd5, 10'd8, 8'sd90, 0);
				send_request(CMD_READ, 10'd5, 10'd8, 8'sd0, 0);
				send_request(CMD_LOAD, 10'd15, 10'd15, 8'sd100, 0);
				send_request(CMD_READ, 10'd15, 10'd15, 8'sd0, 0);
				send_request(CMD_MASK, 10'd0, 10'd0, 8'sd0, 0);      // frees an unknown cell
				send_request(CMD_READ, 10'd0, 10'd0, 8'sd0, 0);
				send_request(CMD_LOAD, 10'd1, 10'd1, -8'sd5, 0);
				send_request(CMD_MASK, 10'd1, 10'd1, 8'sd50, 0);
				send_request(CMD_MASK, 10'd1, 10'd1, -8'sd1, 0);
				send_request(CMD_READ, 10'd1, 10'd1, 8'sd0, 0);
				send_request(CMD_MASK, 10'd1, 10'd1, 8'sd127, 0);
				send_request(CMD_READ, 10'd1, 10'd1, 8'sd0, 0);
				send_request(CMD_MASK, 10'd5, 10'd5, 8'sd100, 0);    // on the robot's cell
				send_request(CMD_READ, 10'd5, 10'd5, 8'sd0, 0);
				send_request(CMD_MASK, 10'd5, 10'd8, 8'sd0, 0);      // free on a known cell
				send_request(CMD_READ, 10'd5, 10'd8, 8'sd0, 0);
				send_request(CMD_READ, 10'd16, 10'd0, 8'sd0, 0);
				send_request(CMD_READ, 10'd1023, 10'd1023, -8'sd1, 0);
				send_request(CMD_LOAD, 10'd1023, 10'd0, 8'sd1, 0);
				send_request(CMD_NONE, 10'd3, 10'd3, 8'sd3, 0);
				send_request(CMD_MASK, 10'd1023, 10'd1023, 8'sd100, 0);
			end
			repeat (ITEMS_PER_PHASE) random_request(gap_percent[phase]);
			settle();
		end

		if (mismatches == 0 && pending == 0)
			$display("[occupancy_grid_clear_and_mask_merge] OK");
		else
			$display("[occupancy_grid_clear_and_mask_merge] ERROR");
		$finish;
	end

endmodule
